FILE: design/bertlv_pkg.sv
`default_nettype none

package bertlv_pkg;

  localparam int DEFAULT_STACK_DEPTH   = 8;
  localparam int DEFAULT_OFFSET_BITS   = 16;
  localparam int DEFAULT_MAX_OID_BYTES = 9;

  // Depth of the queue between the front and the back part.
  localparam int QUEUE_DEPTH = 4;

  localparam int TAG_BITS = 28;
  localparam int NUM_OIDS = 5;
  localparam int OID_COLS = 9;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_MAX_DEPTH   = 2'd0;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_MAX_OFFSET  = 2'd2;
  localparam logic [1:0] CFG_MAX_TRIPLES = 2'd3;

  // Universal tag numbers that steer encapsulation.
  localparam logic [TAG_BITS-1:0] TAG_BIT_STRING   = 28'd3;
  localparam logic [TAG_BITS-1:0] TAG_OCTET_STRING = 28'd4;
  localparam logic [TAG_BITS-1:0] TAG_OID          = 28'd6;

  localparam logic [7:0] OID_TAB [NUM_OIDS][OID_COLS] = '{
    '{8'h55, 8'h1D, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2A, 8'h86, 8'h48, 8'h86, 8'hF7, 8'h0D, 8'h01, 8'h01, 8'h01},
    '{8'h67, 8'h81, 8'h08, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] OID_LEN [NUM_OIDS] = '{4'd3, 4'd3, 4'd3, 4'd9, 4'd6};
  // The OID whose match also depends on the nesting depth.
  localparam int OID_DEPTH_GATED = 4;

  typedef enum logic [2:0] {
    PH_TAG, PH_TAGMORE, PH_LEN1, PH_LENMORE, PH_SKIP, PH_SKIPOID, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INDEF    = 3'd1,
    ST_LEN_CNT  = 3'd2,
    ST_LEN_LIM  = 3'd3,
    ST_OFF_LIM  = 3'd4,
    ST_TRIPLES  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // One input byte with its classification flags.
  typedef struct packed {
    logic [7:0] data;
    logic       sof;
    logic       is_zero;
    logic       tag_long;
    logic       len_long;
    logic       len_bad;
    logic       len_indef;
  } item_t;

  typedef struct packed {
    logic [3:0]  max_depth;
    logic [15:0] max_length;
    logic [15:0] max_offset;
    logic [7:0]  max_triples;
  } cfg_t;

  typedef struct packed {
    logic                walk_done;
    status_e             status;
    logic                encapsulated;
    logic [15:0]         content_length;
    logic [15:0]         content_offset;
    logic [15:0]         header_offset;
    logic [3:0]          nest_depth;
    logic [TAG_BITS-1:0] tag_number;
    logic                constructed;
    logic [1:0]          tag_class;
  } result_t;

  function automatic logic [7:0] oid_byte(input int unsigned k, input logic [3:0] idx);
    logic [7:0] v;
    v = 8'h00;
    if (idx < 4'(OID_COLS)) v = OID_TAB[k][idx];
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/bertlv_front.sv
`default_nettype none

module bertlv_front import bertlv_pkg::*; (
  input  wire logic       s_valid_i,
  input  wire logic [7:0] s_data_i,
  input  wire logic       s_sof_i,
  input  wire logic       q_full_i,
  output logic            s_ready_o,
  output logic            q_push_o,
  output item_t           q_item_o
);

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  // Classify the byte for every role it may take in a header.
  always_comb begin
    q_item_o.data      = s_data_i;
    q_item_o.sof       = s_sof_i;
    q_item_o.is_zero   = (s_data_i == 8'h00);
    q_item_o.tag_long  = (s_data_i[4:0] == 5'b11111);
    q_item_o.len_long  = s_data_i[7];
    q_item_o.len_bad   = s_data_i[7] && (s_data_i[6:0] == 7'd127);
    q_item_o.len_indef = (s_data_i == 8'h80);
  end

endmodule

`default_nettype wire

FILE: design/bertlv_queue.sv
`default_nettype none

module bertlv_queue import bertlv_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/bertlv_back.sv
`default_nettype none

module bertlv_back import bertlv_pkg::*; #(
  parameter int STACK_DEPTH   = DEFAULT_STACK_DEPTH,
  parameter int OFFSET_BITS   = DEFAULT_OFFSET_BITS,
  parameter int MAX_OID_BYTES = DEFAULT_MAX_OID_BYTES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  input  wire logic  empty_i,
  output logic       pop_o,
  output logic       m_valid_o,
  input  wire logic  m_ready_i,
  output result_t    m_result_o
);

  localparam int SD  = STACK_DEPTH;
  localparam int OB  = OFFSET_BITS;
  localparam int DW  = $clog2(SD + 1);
  localparam int SIW = (SD > 1) ? $clog2(SD) : 1;
  localparam int EW  = ((OB > 16) ? OB : 16) + 2;
  localparam logic [OB-1:0] OMAX = '1;

  phase_e              phase_q, phase_d, ph;
  logic [OB-1:0]       off_q, off_d, off;
  logic [TAG_BITS-1:0] tag_q, tag_d, tag;
  logic [1:0]          cls_q, cls_d;
  logic                cons_q, cons_d;
  logic [2:0]          cont_q, cont_d, cont;
  logic [OB-1:0]       hstart_q, hstart_d;
  logic [15:0]         len_q, len_d, len;
  logic [6:0]          left_q, left_d, left;
  logic [OB-1:0]       skip_q, skip_d, skip;
  logic [OB-1:0]       stack_q [SD];
  logic [DW-1:0]       depth_q, depth_d, depth;
  logic [8:0]          trip_q, trip_d, trip;
  logic [OB-1:0]       outer_q, outer_d, outer;
  logic [NUM_OIDS-1:0] mask_q, mask_d, mask;
  logic [3:0]          oidx_q, oidx_d, oidx;
  logic                enc_q, enc_d, enc;

  logic [OB:0]         nxt;
  logic [EW-1:0]       endv;
  logic [5:0]          lim;
  logic [7:0]          b;
  logic                hdr_done, consumed, enter, is_oid, push, emit;
  status_e             status;
  result_t             res;
  logic                out_valid_q;
  result_t             out_q;

  assign pop_o      = !empty_i && (!out_valid_q || m_ready_i);
  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;
  assign b          = item_i.data;

  always_comb begin
    // A start-of-file byte sees the walk as freshly reset.
    ph     = item_i.sof ? PH_TAG : phase_q;
    off    = item_i.sof ? '0 : off_q;
    tag    = item_i.sof ? '0 : tag_q;
    cont   = item_i.sof ? '0 : cont_q;
    len    = item_i.sof ? '0 : len_q;
    left   = item_i.sof ? '0 : left_q;
    skip   = item_i.sof ? '0 : skip_q;
    depth  = item_i.sof ? DW'(1) : depth_q;
    trip   = item_i.sof ? '0 : trip_q;
    outer  = item_i.sof ? '0 : outer_q;
    mask   = item_i.sof ? '1 : mask_q;
    oidx   = item_i.sof ? '0 : oidx_q;
    enc    = item_i.sof ? 1'b0 : enc_q;

    phase_d  = ph;
    off_d    = off;
    tag_d    = tag;
    cls_d    = item_i.sof ? 2'b00 : cls_q;
    cons_d   = item_i.sof ? 1'b0 : cons_q;
    cont_d   = cont;
    hstart_d = item_i.sof ? '0 : hstart_q;
    len_d    = len;
    left_d   = left;
    skip_d   = skip;
    depth_d  = depth;
    trip_d   = trip;
    outer_d  = outer;
    mask_d   = mask;
    oidx_d   = oidx;
    enc_d    = enc;

    nxt      = {1'b0, off} + 1'b1;
    endv     = EW'(nxt) + EW'(len);
    lim      = (cfg_i.max_depth == 4'd0) ? 6'd1 :
               ((6'(cfg_i.max_depth) > 6'(SD)) ? 6'(SD) : 6'(cfg_i.max_depth));
    hdr_done = 1'b0;
    consumed = 1'b0;
    enter    = 1'b0;
    is_oid   = 1'b0;
    push     = 1'b0;
    emit     = 1'b0;
    status   = ST_OK;
    res      = '0;

    if (ph != PH_DONE) begin
      unique case (ph)
        PH_TAG: begin
          if (!item_i.is_zero) begin
            hstart_d = off;
            cls_d    = b[7:6];
            cons_d   = b[5];
            cont_d   = 3'd0;
            if (item_i.tag_long) begin
              tag_d   = '0;
              phase_d = PH_TAGMORE;
            end else begin
              tag_d   = TAG_BITS'(b[4:0]);
              phase_d = PH_LEN1;
            end
          end
        end
        PH_TAGMORE: begin
          if (cont >= 3'd4) begin
            status = ST_OVERFLOW;
          end else begin
            tag_d  = {tag[TAG_BITS-8:0], b[6:0]};
            cont_d = cont + 3'd1;
            if (!b[7]) phase_d = PH_LEN1;
          end
        end
        PH_LEN1: begin
          if (item_i.len_indef) begin
            status = ST_INDEF;
          end else if (item_i.len_long) begin
            if (item_i.len_bad) begin
              status = ST_LEN_CNT;
            end else begin
              len_d   = '0;
              left_d  = b[6:0];
              phase_d = PH_LENMORE;
            end
          end else begin
            len_d    = {8'h00, b};
            hdr_done = 1'b1;
          end
        end
        PH_LENMORE: begin
          if (len[15:8] != 8'h00) begin
            status = ST_OVERFLOW;
          end else begin
            len_d    = {len[7:0], b};
            left_d   = (left != 7'd0) ? left - 7'd1 : 7'd0;
            hdr_done = (left <= 7'd1);
          end
        end
        PH_SKIP, PH_SKIPOID: begin
          if (ph == PH_SKIPOID) begin
            for (int k = 0; k < NUM_OIDS; k++) begin
              mask_d[k] = mask[k] && (oidx < OID_LEN[k]) && (oid_byte(k, oidx) == b);
            end
            if (oidx != 4'd15) oidx_d = oidx + 4'd1;
          end
          if (nxt >= {1'b0, skip}) begin
            if (ph == PH_SKIPOID) enc_d = (mask_d != '0);
            phase_d = PH_TAG;
          end
        end
        default: ;
      endcase

      // The length is final only once the header completes.
      endv = EW'(nxt) + EW'(len_d);

      if (status != ST_OK) begin
        res.tag_class     = cls_d;
        res.constructed   = cons_d;
        res.tag_number    = tag_d;
        res.nest_depth    = 4'(depth);
        res.header_offset = 16'(hstart_d);
        res.status        = status;
        res.walk_done     = 1'b1;
        emit              = 1'b1;
        phase_d           = PH_DONE;
      end else begin
        if (hdr_done) begin
          trip_d = (trip == 9'd511) ? trip : trip + 9'd1;
          is_oid = (tag_d == TAG_OID);
          if (is_oid) begin
            enc_d = 1'b0;
          end else if ((tag_d == TAG_BIT_STRING || tag_d == TAG_OCTET_STRING) && enc) begin
            consumed = 1'b1;
            enc_d    = 1'b0;
          end
          enter = (cons_d || consumed) && (len_d != 16'd0) && (6'(depth) < lim);

          if (len_d > cfg_i.max_length) status = ST_LEN_LIM;
          else if (EW'(nxt) > EW'(cfg_i.max_offset) || nxt[OB] || endv > EW'(OMAX))
            status = ST_OFF_LIM;
          else if (trip_d > {1'b0, cfg_i.max_triples}) status = ST_TRIPLES;

          res.tag_class      = cls_d;
          res.constructed    = cons_d;
          res.tag_number     = tag_d;
          res.nest_depth     = 4'(depth);
          res.header_offset  = 16'(hstart_d);
          res.content_offset = 16'(nxt);
          res.content_length = len_d;
          res.encapsulated   = consumed && enter;
          res.status         = status;
          emit               = 1'b1;
          if (outer == '0) outer_d = endv[OB-1:0];

          if (status != ST_OK) begin
            res.walk_done = 1'b1;
            phase_d       = PH_DONE;
          end else if (enter) begin
            push    = 1'b1;
            depth_d = depth + 1'b1;
            phase_d = PH_TAG;
          end else if (len_d == 16'd0) begin
            phase_d = PH_TAG;
          end else begin
            skip_d = endv[OB-1:0];
            if (is_oid && !cons_d) begin
              for (int k = 0; k < NUM_OIDS; k++) begin
                mask_d[k] = (16'(OID_LEN[k]) == len_d) && (int'(OID_LEN[k]) <= MAX_OID_BYTES);
              end
              if (6'(depth) >= lim) mask_d[OID_DEPTH_GATED] = 1'b0;
              oidx_d  = 4'd0;
              phase_d = PH_SKIPOID;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end

        if (status == ST_OK) begin
          off_d = nxt[OB] ? OMAX : nxt[OB-1:0];
          if (phase_d == PH_TAG) begin
            // Shallowest parent whose end is reached wins; a fresh push never pops.
            for (int k = SD - 1; k >= 0; k--) begin
              if ((k + 1) < int'(depth) && {1'b0, stack_q[k]} <= nxt) depth_d = DW'(k + 1);
            end
            if (outer_d != '0 && nxt >= {1'b0, outer_d}) begin
              phase_d       = PH_DONE;
              res.walk_done = 1'b1;
              emit          = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && push) stack_q[SIW'(depth - 1'b1)] <= endv[OB-1:0];
    if (pop_o && emit) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      off_q       <= '0;
      tag_q       <= '0;
      cls_q       <= '0;
      cons_q      <= 1'b0;
      cont_q      <= '0;
      hstart_q    <= '0;
      len_q       <= '0;
      left_q      <= '0;
      skip_q      <= '0;
      depth_q     <= DW'(1);
      trip_q      <= '0;
      outer_q     <= '0;
      mask_q      <= '1;
      oidx_q      <= '0;
      enc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q  <= phase_d;
        off_q    <= off_d;
        tag_q    <= tag_d;
        cls_q    <= cls_d;
        cons_q   <= cons_d;
        cont_q   <= cont_d;
        hstart_q <= hstart_d;
        len_q    <= len_d;
        left_q   <= left_d;
        skip_q   <= skip_d;
        depth_q  <= depth_d;
        trip_q   <= trip_d;
        outer_q  <= outer_d;
        mask_q   <= mask_d;
        oidx_q   <= oidx_d;
        enc_q    <= enc_d;
      end
      if (pop_o && emit) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/ber_tlv_stream_walker.sv
// BER TLV stream walker.
// The slave stream carries one byte of a BER encoded file per transaction in
// s_axis_tdata, with s_axis_tuser high on the first byte of a file; that
// byte restarts the walk at offset zero. The master stream carries one
// record per completed TLV header (identifier, depth, offsets and length),
// with the status code in m_axis_tuser and m_axis_tlast high on the last
// record of a walk. Errors, and reaching the end of the first item, end the
// walk; an end record with all fields zero is sent when no header completes
// on that byte. Later bytes are dropped until the next start of file.
// A front part classifies each byte and writes it into a four-entry queue;
// the back part decodes one byte per cycle into an output register while the
// receiver does not stall. The byte that completes a record waits in the
// queue, and the record is then registered in the output register. When the
// receiver stalls, the output register holds the record and the queue
// absorbs up to four more bytes before s_axis_tready drops. Reset clears the
// walk state, sets the depth limit to 8 and the other limits to their largest
// values; the nesting stack needs no clearing. Configuration registers are
// written through cfg_we_i, cfg_addr_i and cfg_wdata_i by the user only while
// the walker is idle; the block does not enforce this.

`default_nettype none

module ber_tlv_stream_walker import bertlv_pkg::*; #(
  parameter int STACK_DEPTH   = DEFAULT_STACK_DEPTH,
  parameter int OFFSET_BITS   = DEFAULT_OFFSET_BITS,
  parameter int MAX_OID_BYTES = DEFAULT_MAX_OID_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // start_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tag_class[1:0], constructed[2], tag_number[30:3], nest_depth[34:31],
  // header_offset[50:35], content_offset[66:51], content_length[82:67],
  // encapsulated[83], zero fill[87:84]
  output logic [87:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // status
  output logic             m_axis_tlast    // walk_done
);

  cfg_t    cfg_q;
  item_t   f_item, q_item;
  logic    q_push, q_full, q_pop, q_empty;
  result_t res;

  // Limit registers; each write lands on the next clock edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_depth   <= 4'd8;
      cfg_q.max_length  <= 16'hFFFF;
      cfg_q.max_offset  <= 16'hFFFF;
      cfg_q.max_triples <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MAX_DEPTH:   cfg_q.max_depth   <= cfg_wdata_i[3:0];
        CFG_MAX_LENGTH:  cfg_q.max_length  <= cfg_wdata_i;
        CFG_MAX_OFFSET:  cfg_q.max_offset  <= cfg_wdata_i;
        CFG_MAX_TRIPLES: cfg_q.max_triples <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  bertlv_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_sof_i   (s_axis_tuser),
    .q_full_i  (q_full),
    .s_ready_o (s_axis_tready),
    .q_push_o  (q_push),
    .q_item_o  (f_item)
  );

  bertlv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  bertlv_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .OFFSET_BITS   (OFFSET_BITS),
    .MAX_OID_BYTES (MAX_OID_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (q_item),
    .empty_i    (q_empty),
    .pop_o      (q_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (res)
  );

  assign m_axis_tdata = {4'b0000, res.encapsulated, res.content_length, res.content_offset,
                         res.header_offset, res.nest_depth, res.tag_number,
                         res.constructed, res.tag_class};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.walk_done;

endmodule

`default_nettype wire

FILE: design/bertlv_checker.sv
`default_nettype none

module bertlv_checker import bertlv_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled record holds its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output record changed while stalled");

  // Any error ends the walk.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast)
    else $error("error record without walk end");

  // A record in mid walk always has a real depth.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:31] != 4'd0)
    else $error("record with zero depth");

  // The queue takes bytes whenever the output side drains.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !s_axis_tvalid |=> s_axis_tready)
    else $error("input stalled with idle output");

endmodule

bind ber_tlv_stream_walker bertlv_checker u_bertlv_checker (.*);

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

// Self-checking bench for the BER TLV stream walker. Each file is
// streamed as one byte per transaction. Every accepted byte is run
// through a behavioral walker in this module, and the record that it
// predicts is queued. A separate process checks each record that
// leaves the master stream against the oldest queued record, field by
// field.
module tb;
  import bertlv_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tuser;   // start_of_file
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // tag_class, constructed, tag_number, nest_depth, header_offset,
  // content_offset, content_length, encapsulated, zero fill (lowest bit up)
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // status
  logic        m_axis_tlast;   // walk_done

  ber_tlv_stream_walker dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .m_axis_tlast
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bench bookkeeping.
  result_t     pending_records[$];
  int          error_count;
  int          bytes_sent;
  int          records_seen;
  int          files_sent;
  int          rx_hold;       // long stall requested by a test
  bit          tx_busy;       // when clear, the sender adds no random gaps
  bit          rx_busy;       // when clear, the receiver adds no random stalls
  int          cycles;

  // Limit registers as the walker sees them.
  logic [3:0]  lim_depth;
  logic [15:0] lim_length;
  logic [15:0] lim_offset;
  logic [7:0]  lim_triples;

  // Behavioral walker state.
  int unsigned w_offset;
  phase_e      w_phase;
  logic [27:0] w_tag;
  logic [5:0]  w_ident;       // class, constructed, continuation count
  int unsigned w_hstart;
  int unsigned w_length;
  int          w_len_left;
  int unsigned w_skip_end;
  int unsigned w_ends [8];
  int          w_depth;
  int          w_records;
  int unsigned w_outer_end;
  logic [4:0]  w_oid_mask;
  int          w_oid_idx;
  bit          w_encap_next;
  bit          w_stopped;

  task automatic clear_walk();
    w_offset = 0;
    w_phase = PH_TAG;
    w_tag = '0;
    w_ident = '0;
    w_hstart = 0;
    w_length = 0;
    w_len_left = 0;
    w_skip_end = 0;
    foreach (w_ends[k]) w_ends[k] = 0;
    w_depth = 1;
    w_records = 0;
    w_outer_end = 0;
    w_oid_mask = '1;
    w_oid_idx = 0;
    w_encap_next = 1'b0;
    w_stopped = 1'b0;
  endtask

  function automatic result_t header_part(result_t r);
    r.tag_class = w_ident[1:0];
    r.constructed = w_ident[2];
    r.tag_number = w_tag;
    r.nest_depth = 4'(w_depth);
    r.header_offset = w_hstart[15:0];
    return r;
  endfunction

  // Advances the walker by one accepted byte and queues the record that
  // the byte produces, if any.
  task automatic walk_byte(input logic [7:0] b, input bit sof);
    int unsigned here, nxt, clen, fin;
    status_e     st;
    bit          emit, hdr_done, cons, is_oid, used, enter;
    int          lim, d;
    logic [2:0]  cont;
    result_t     r;

    if (sof) clear_walk();
    if (w_stopped || w_phase == PH_DONE) return;
    r = '0;
    st = ST_OK;
    emit = 1'b0;
    hdr_done = 1'b0;
    here = w_offset;
    nxt = here + 1;

    case (w_phase)
      PH_TAG: begin
        if (b != 8'h00) begin
          w_hstart = here;
          w_ident = {3'd0, b[5], b[7:6]};
          if (b[4:0] == 5'h1F) begin
            w_tag = '0;
            w_phase = PH_TAGMORE;
          end else begin
            w_tag = 28'(b[4:0]);
            w_phase = PH_LEN1;
          end
        end
      end
      PH_TAGMORE: begin
        cont = w_ident[5:3];
        if (cont >= 3'd4) begin
          st = ST_OVERFLOW;
        end else begin
          w_tag = {w_tag[20:0], b[6:0]};
          w_ident[5:3] = cont + 3'd1;
          if (!b[7]) w_phase = PH_LEN1;
        end
      end
      PH_LEN1: begin
        if (b == 8'h80) begin
          st = ST_INDEF;
        end else if (b[7]) begin
          if (b[6:0] == 7'h7F) begin
            st = ST_LEN_CNT;
          end else begin
            w_length = 0;
            w_len_left = int'(b[6:0]);
            w_phase = PH_LENMORE;
          end
        end else begin
          w_length = b;
          hdr_done = 1'b1;
        end
      end
      PH_LENMORE: begin
        if ((w_length >> 8) != 0) begin
          st = ST_OVERFLOW;
        end else begin
          w_length = ((w_length << 8) | b) & 32'hFFFF;
          if (w_len_left > 0) w_len_left--;
          if (w_len_left == 0) hdr_done = 1'b1;
        end
      end
      default: begin
        // Skipping content; an OID body is compared against the table.
        if (w_phase == PH_SKIPOID) begin
          for (int k = 0; k < NUM_OIDS; k++) begin
            if (w_oid_mask[k]) begin
              if (w_oid_idx >= int'(OID_LEN[k]) || OID_TAB[k][w_oid_idx] != b)
                w_oid_mask[k] = 1'b0;
            end
          end
          if (w_oid_idx < 15) w_oid_idx++;
        end
        if (nxt >= w_skip_end) begin
          if (w_phase == PH_SKIPOID) w_encap_next = (w_oid_mask != 0);
          w_phase = PH_TAG;
        end
      end
    endcase

    if (st != ST_OK) begin
      r = header_part(r);
      r.status = st;
      r.walk_done = 1'b1;
      w_stopped = 1'b1;
      w_phase = PH_DONE;
      pending_records.push_back(r);
      return;
    end

    if (hdr_done) begin
      clen = w_length;
      fin = nxt + clen;
      cons = w_ident[2];
      lim = (lim_depth < 1) ? 1 : (lim_depth > 8) ? 8 : int'(lim_depth);
      d = w_depth;
      is_oid = (w_tag == TAG_OID);
      used = 1'b0;
      if (w_records < 511) w_records++;
      if (is_oid) begin
        w_encap_next = 1'b0;
      end else if ((w_tag == TAG_BIT_STRING || w_tag == TAG_OCTET_STRING) && w_encap_next) begin
        used = 1'b1;
        w_encap_next = 1'b0;
      end
      enter = (cons || used) && clen > 0 && d < lim;

      if (clen > lim_length) st = ST_LEN_LIM;
      else if (nxt > lim_offset || nxt > 65535 || fin > 65535) st = ST_OFF_LIM;
      else if (w_records > int'(lim_triples)) st = ST_TRIPLES;

      r = header_part(r);
      r.content_offset = nxt[15:0];
      r.content_length = clen[15:0];
      r.encapsulated = used && enter;
      r.status = st;
      emit = 1'b1;
      if (w_outer_end == 0) w_outer_end = fin;

      if (st != ST_OK) begin
        r.walk_done = 1'b1;
        w_stopped = 1'b1;
        w_phase = PH_DONE;
        pending_records.push_back(r);
        return;
      end
      if (enter) begin
        w_ends[d-1] = fin;
        w_depth = d + 1;
        w_phase = PH_TAG;
      end else if (clen == 0) begin
        w_phase = PH_TAG;
      end else begin
        w_skip_end = fin;
        if (is_oid && !cons) begin
          w_oid_mask = '0;
          for (int k = 0; k < NUM_OIDS; k++)
            if (int'(OID_LEN[k]) == clen && OID_LEN[k] <= 9) w_oid_mask[k] = 1'b1;
          if (d + 1 > lim) w_oid_mask[OID_DEPTH_GATED] = 1'b0;
          w_oid_idx = 0;
          w_phase = PH_SKIPOID;
        end else begin
          w_phase = PH_SKIP;
        end
      end
    end

    w_offset = (nxt > 65535) ? 65535 : nxt;

    if (w_phase == PH_TAG) begin
      // The shallowest parent that has ended is popped with all above it.
      for (int k = 0; k + 1 < w_depth && k < 8; k++) begin
        if (w_ends[k] <= nxt) begin
          w_depth = k + 1;
          break;
        end
      end
      if (w_outer_end != 0 && nxt >= w_outer_end) begin
        w_stopped = 1'b1;
        w_phase = PH_DONE;
        r.walk_done = 1'b1;
        emit = 1'b1;
      end
    end
    if (emit) pending_records.push_back(r);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on record %0d: %s is %0h, expected %0h", records_seen, what, got,
             want);
    error_count++;
  endtask

  task automatic check_record();
    result_t want;
    if (pending_records.size() == 0) begin
      report("outstanding records", 0, 1);
      return;
    end
    want = pending_records.pop_front();
    if (m_axis_tdata[1:0] != want.tag_class)
      report("tag_class", m_axis_tdata[1:0], want.tag_class);
    if (m_axis_tdata[2] != want.constructed)
      report("constructed", m_axis_tdata[2], want.constructed);
    if (m_axis_tdata[30:3] != want.tag_number)
      report("tag_number", m_axis_tdata[30:3], want.tag_number);
    if (m_axis_tdata[34:31] != want.nest_depth)
      report("nest_depth", m_axis_tdata[34:31], want.nest_depth);
    if (m_axis_tdata[50:35] != want.header_offset)
      report("header_offset", m_axis_tdata[50:35], want.header_offset);
    if (m_axis_tdata[66:51] != want.content_offset)
      report("content_offset", m_axis_tdata[66:51], want.content_offset);
    if (m_axis_tdata[82:67] != want.content_length)
      report("content_length", m_axis_tdata[82:67], want.content_length);
    if (m_axis_tdata[83] != want.encapsulated)
      report("encapsulated", m_axis_tdata[83], want.encapsulated);
    if (m_axis_tuser != want.status)
      report("status", m_axis_tuser, want.status);
    if (m_axis_tlast != want.walk_done)
      report("walk_done", m_axis_tlast, want.walk_done);
  endtask

  // Receiver: checks each record, then stalls a random number of cycles,
  // or for the long stretch that a test asks for.
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        check_record();
        records_seen++;
        stall = rx_busy ? $urandom_range(0, 8) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

  // Offers one byte and returns at the edge where it is accepted. The
  // valid stays high when no gap follows, so back-to-back transactions
  // never lower and raise it in the same step.
  task automatic send_byte(input logic [7:0] b, input bit sof);
    int gap;
    gap = tx_busy ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= sof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    walk_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic send_file(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], i == 0);
    files_sent++;
  endtask

  // Stops offering and waits until every predicted record has left, plus
  // the pipeline latency for bytes that produce no record.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all four limit registers, one per cycle, while idle.
  task automatic set_limits(input logic [3:0] dep, input logic [15:0] len,
                            input logic [15:0] off, input logic [7:0] trip);
    drain();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= CFG_MAX_DEPTH;
    cfg_wdata_i <= 16'(dep);
    @(posedge clk_i);
    cfg_addr_i <= CFG_MAX_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_addr_i <= CFG_MAX_OFFSET;
    cfg_wdata_i <= off;
    @(posedge clk_i);
    cfg_addr_i <= CFG_MAX_TRIPLES;
    cfg_wdata_i <= 16'(trip);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_depth = dep;
    lim_length = len;
    lim_offset = off;
    lim_triples = trip;
  endtask

  task automatic put_length(ref byte_q_t q, input int n);
    if (n < 128 && $urandom_range(0, 3) != 0) begin
      q.push_back(8'(n));
    end else if (n < 256 && $urandom_range(0, 1) == 1) begin
      q.push_back(8'h81);
      q.push_back(8'(n));
    end else begin
      // Long form with two octets, possibly with a leading zero.
      q.push_back(8'h82);
      q.push_back(8'(n >> 8));
      q.push_back(8'(n));
    end
  endtask

  task automatic put_tlv(ref byte_q_t q, input logic [7:0] id, input byte_q_t body);
    q.push_back(id);
    put_length(q, body.size());
    foreach (body[i]) q.push_back(body[i]);
  endtask

  // Appends one random element (sometimes an OID followed by a string that
  // encapsulates further elements).
  task automatic build_element(input int lvl, ref byte_q_t q);
    byte_q_t body, inner;
    int      kind, n, k;
    if ($urandom_range(0, 7) == 0) q.push_back(8'h00);
    kind = (lvl < 4) ? $urandom_range(0, 9) : $urandom_range(6, 9);
    if (kind < 4) begin
      n = $urandom_range(0, 3);
      repeat (n) build_element(lvl + 1, body);
      put_tlv(q, kind[0] ? 8'h30 : 8'(8'hA0 | $urandom_range(0, 31)), body);
    end else if (kind < 6) begin
      k = $urandom_range(0, NUM_OIDS - 1);
      for (int i = 0; i < int'(OID_LEN[k]); i++) body.push_back(OID_TAB[k][i]);
      if ($urandom_range(0, 4) == 0) body[$urandom_range(0, body.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 5) == 0) body.push_back(8'h01);
      put_tlv(q, 8'h06, body);
      repeat ($urandom_range(1, 2)) build_element(lvl + 1, inner);
      put_tlv(q, $urandom_range(0, 1) ? TAG_OCTET_STRING[7:0] : TAG_BIT_STRING[7:0], inner);
    end else begin
      n = $urandom_range(0, 5);
      repeat (n) body.push_back(8'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        // Multi-octet tag number with one to four continuation octets.
        q.push_back({2'($urandom), 1'b0, 5'h1F});
        k = $urandom_range(1, 4);
        for (int i = 1; i < k; i++) q.push_back({1'b1, 7'($urandom)});
        q.push_back({1'b0, 7'($urandom)});
        put_length(q, n);
        foreach (body[i]) q.push_back(body[i]);
      end else begin
        put_tlv(q, {2'($urandom), 1'b0, 5'($urandom_range(1, 30))}, body);
      end
    end
  endtask

  task automatic test_basic_headers();
    send_file('{8'h30, 8'h06, 8'h02, 8'h01, 8'h05, 8'h04, 8'h01, 8'hAA, 8'h00, 8'hFF});
    send_file('{8'h00, 8'h00, 8'h02, 8'h01, 8'h7F});
    send_file('{8'hDF, 8'h81, 8'h01, 8'h00});
    send_file('{8'h04, 8'h82, 8'h00, 8'h02, 8'hAA, 8'hBB});
    send_file('{8'h30, 8'h00, 8'h05});
  endtask

  task automatic test_errors();
    send_file('{8'h1F, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h81});
    send_file('{8'h30, 8'h80});
    send_file('{8'h04, 8'hFF});
    send_file('{8'h04, 8'h83, 8'h01, 8'h00, 8'h00});
    send_file('{8'h30, 8'h82, 8'hFF, 8'hFF});
  endtask

  task automatic test_nesting();
    // Encapsulation after a short and after the nine-byte OID.
    send_file('{8'h30, 8'h0F, 8'h06, 8'h03, 8'h55, 8'h1D, 8'h0E, 8'h04, 8'h08,
                8'h30, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h02});
    send_file('{8'h30, 8'h10, 8'h06, 8'h09, 8'h2A, 8'h86, 8'h48, 8'h86, 8'hF7,
                8'h0D, 8'h01, 8'h01, 8'h01, 8'h03, 8'h03, 8'h02, 8'h01, 8'h09});
    // Constructed OID, and a child that runs past its parent.
    send_file('{8'h30, 8'h04, 8'h26, 8'h02, 8'h05, 8'h00});
    send_file('{8'h30, 8'h05, 8'h30, 8'h06, 8'h01, 8'h01, 8'h00, 8'h02, 8'h01, 8'h00});
    // Depth-gated OID at the depth limit.
    set_limits(4'd2, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_file('{8'h30, 8'h0B, 8'h06, 8'h06, 8'h67, 8'h81, 8'h08, 8'h01, 8'h01, 8'h01,
                8'h04, 8'h01, 8'h00});
    set_limits(4'd1, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_file('{8'h30, 8'h03, 8'h02, 8'h01, 8'h00});
  endtask

  task automatic test_limits();
    set_limits(4'd15, 16'd0, 16'hFFFF, 8'hFF);
    send_file('{8'h04, 8'h01, 8'h00});
    set_limits(4'd8, 16'hFFFF, 16'd0, 8'hFF);
    send_file('{8'h05, 8'h00});
    set_limits(4'd8, 16'hFFFF, 16'hFFFF, 8'd0);
    send_file('{8'h30, 8'h00});
    set_limits(4'd8, 16'hFFFF, 16'hFFFF, 8'd2);
    send_file('{8'h30, 8'h06, 8'h05, 8'h00, 8'h05, 8'h00, 8'h05, 8'h00});
    set_limits(4'd8, 16'hFFFF, 16'hFFFF, 8'hFF);
  endtask

  // The receiver holds off for a long stretch while bytes keep coming, so
  // the queue fills and the input stalls; afterwards the sender waits for
  // every record to leave.
  task automatic test_backpressure();
    byte_q_t q;
    tx_busy = 1'b0;
    q.push_back(8'h30);
    q.push_back(8'd40);
    repeat (20) begin
      q.push_back(8'h05);
      q.push_back(8'h00);
    end
    rx_hold = 150;
    send_file(q);
    drain();
    tx_busy = 1'b1;
  endtask

  task automatic test_random_files();
    byte_q_t q;
    int      pick;
    while (bytes_sent < 1170) begin
      q.delete();
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        build_element(0, q);
      end else if (pick < 9) begin
        build_element(0, q);
        q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
      end else begin
        repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) q.push_back(8'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        tx_busy = 1'($urandom_range(0, 1));
        rx_busy = 1'($urandom_range(0, 1));
      end
      send_file(q);
      if ($urandom_range(0, 14) == 0)
        set_limits(4'($urandom_range(1, 8)),
                   $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 8)) : 16'hFFFF,
                   $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 30)) : 16'hFFFF,
                   $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 6)) : 8'hFF);
    end
    tx_busy = 1'b1;
    rx_busy = 1'b1;
  endtask

  initial begin
    error_count = 0;
    bytes_sent = 0;
    records_seen = 0;
    files_sent = 0;
    rx_hold = 0;
    tx_busy = 1'b1;
    rx_busy = 1'b1;
    lim_depth = 4'd8;
    lim_length = 16'hFFFF;
    lim_offset = 16'hFFFF;
    lim_triples = 8'hFF;
    clear_walk();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_addr_i <= CFG_MAX_DEPTH;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_headers();
    test_errors();
    test_nesting();
    test_limits();
    test_backpressure();
    test_random_files();
    set_limits(4'd8, 16'hFFFF, 16'hFFFF, 8'hFF);
    test_basic_headers();

    drain();
    $display("Streamed %0d bytes in %0d files and checked %0d records,", bytes_sent,
             files_sent, records_seen);
    $display("covering errors, nesting, encapsulation, limits and back pressure.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: ber_tlv_stream_walker.f
design/bertlv_pkg.sv
design/bertlv_front.sv
design/bertlv_queue.sv
design/bertlv_back.sv
design/ber_tlv_stream_walker.sv
design/bertlv_checker.sv
dv/tb.sv
